@@ rtl/smm_pkg.sv @@
// shared types, constants and functions of the scaled matrix multiplier
package smm_pkg;

    localparam int MAX_DIM_DEF     = 8;
    localparam int MODEL_WIDTH_DEF = 6;
    localparam int FRAC_BITS       = 6;
    localparam int ELEM_W          = 8;
    localparam int IDX_W           = 3;
    localparam int DIM_W           = 4;
    localparam int MAG_W           = ELEM_W + FRAC_BITS;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PADDR_W         = 5;
    localparam int PDATA_W         = 32;

    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_START  = 2'd2;

    localparam logic [2:0] REG_ROWS_M    = 3'd0;
    localparam logic [2:0] REG_INNER_N   = 3'd1;
    localparam logic [2:0] REG_COLS_K    = 3'd2;
    localparam logic [2:0] REG_TRANSPOSE = 3'd3;
    localparam logic [2:0] REG_SCALE     = 3'd4;

    localparam logic [DIM_W-1:0] RESET_ROWS_M  = 4'd6;
    localparam logic [DIM_W-1:0] RESET_INNER_N = 4'd6;
    localparam logic [DIM_W-1:0] RESET_COLS_K  = 4'd4;

    typedef struct packed {
        logic [DIM_W-1:0] rows_m;
        logic [DIM_W-1:0] inner_n;
        logic [DIM_W-1:0] cols_k;
        logic             transpose_b;
        logic             scale_by_root_dmodel;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } t_cmd;

    // 64 * sqrt(width), rounded to nearest
    function automatic int root_scale(input int width);
        int x;
        int r;
        x = width * 4096;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r++;
        if (x - r * r > r) r++;
        if (r == 0) r = 1;
        return r;
    endfunction

endpackage

@@ rtl/smm_ram.sv @@
// generic single-write, single-read ram with registered read data
module smm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/smm_div.sv @@
// floor division of a scaled sum by a fixed divisor through reciprocal multiplication
module smm_div #(
    parameter int DIVISOR = smm_pkg::root_scale(smm_pkg::MODEL_WIDTH_DEF)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [smm_pkg::ELEM_W-1:0] i_sum,
    output logic                      o_done,
    output logic [smm_pkg::ELEM_W-1:0] o_quot
);

    localparam int EW    = smm_pkg::ELEM_W;
    localparam int NumW  = smm_pkg::MAG_W + 1;
    localparam int Sh    = NumW + $clog2(DIVISOR);
    localparam int RecW  = NumW + 2;
    localparam int ProdW = NumW + RecW;
    localparam logic [RecW-1:0] Recip =
        RecW'(((longint'(1) << Sh) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

    logic             r_done;
    logic [EW-1:0]    r_quot;

    logic             neg;
    logic [EW-1:0]    mag;
    logic [NumW-1:0]  num;
    logic [ProdW-1:0] prod;
    logic [EW-1:0]    q;

    assign neg  = i_sum[EW-1];
    assign mag  = neg ? (~i_sum + 1'b1) : i_sum;
    // floor for negative sums: bias the magnitude by divisor - 1
    assign num  = {1'b0, mag, {smm_pkg::FRAC_BITS{1'b0}}}
                + (neg ? NumW'(DIVISOR - 1) : '0);
    assign prod = ProdW'(num) * ProdW'(Recip);
    assign q    = prod[Sh +: EW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= neg ? (~q + 1'b1) : q;
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

@@ rtl/smm_front.sv @@
// input side: accepts beats, drops ignored requests, queues commands
module smm_front #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [smm_pkg::IDX_W-1:0]     i_row_index,
    input  logic [smm_pkg::IDX_W-1:0]     i_col_index,
    input  logic [smm_pkg::ELEM_W-1:0]    i_element_value,
    output smm_pkg::t_cmd                 o_cmd,
    output logic                          o_cmd_valid,
    input  logic                          i_cmd_pop
);

    localparam int Depth = smm_pkg::QUEUE_DEPTH;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    smm_pkg::t_cmd   r_q [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    logic in_range;
    logic keep;
    logic push;
    logic pop;

    assign in_range = ({1'b0, i_row_index} < (smm_pkg::IDX_W + 1)'(MAX_DIM))
                   && ({1'b0, i_col_index} < (smm_pkg::IDX_W + 1)'(MAX_DIM));
    assign keep = (i_req_type == smm_pkg::REQ_START)
               || (((i_req_type == smm_pkg::REQ_LOAD_A)
                 || (i_req_type == smm_pkg::REQ_LOAD_B)) && in_range);

    assign o_in_ready  = (r_count != CntW'(Depth));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready && keep;
    assign pop         = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{kind: i_req_type, row: i_row_index,
                               col: i_col_index, value: i_element_value};
        end
    end

endmodule

@@ rtl/smm_back.sv @@
// execution side: matrix stores, multiply-accumulate sequencer, scaling, result register
module smm_back #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF,
    parameter int DIVISOR = smm_pkg::root_scale(smm_pkg::MODEL_WIDTH_DEF)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  smm_pkg::t_cfg                 i_cfg,
    input  smm_pkg::t_cmd                 i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [smm_pkg::IDX_W-1:0]     o_out_row,
    output logic [smm_pkg::IDX_W-1:0]     o_out_col,
    output logic [smm_pkg::ELEM_W-1:0]    o_out_value,
    output logic                          o_last
);

    localparam int AddrW = $clog2(MAX_DIM * MAX_DIM);
    localparam int DW    = smm_pkg::DIM_W;
    localparam int IW    = smm_pkg::IDX_W;
    localparam int EW    = smm_pkg::ELEM_W;
    localparam int FB    = smm_pkg::FRAC_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        return (v > DW'(MAX_DIM)) ? DW'(MAX_DIM) : v;
    endfunction

    function automatic logic [AddrW-1:0] elem_addr(input logic [IW-1:0] r,
                                                   input logic [IW-1:0] c);
        return AddrW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [DW-1:0]           r_m;
    logic [DW-1:0]           r_n;
    logic [DW-1:0]           r_k;
    logic                    r_tr;
    logic                    r_sc;
    logic [IW-1:0]           r_i;
    logic [IW-1:0]           r_j;
    logic [IW-1:0]           r_t;
    logic                    r_v1;
    logic                    r_v2;
    logic signed [2*EW-1:0]  r_prod;
    logic [EW-1:0]           r_acc;
    logic                    r_out_valid;
    logic [IW-1:0]           r_out_row;
    logic [IW-1:0]           r_out_col;
    logic [EW-1:0]           r_out_value;
    logic                    r_out_last;

    logic [DW-1:0]    m_c;
    logic [DW-1:0]    n_c;
    logic [DW-1:0]    k_c;
    logic             start_go;
    logic             t_last;
    logic             elem_last;
    logic             pipe_empty;
    logic             out_free;
    logic             a_we;
    logic             b_we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] a_raddr;
    logic [AddrW-1:0] b_raddr;
    logic [EW-1:0]    a_rdata;
    logic [EW-1:0]    b_rdata;
    logic             div_start;
    logic             div_done;
    logic [EW-1:0]    div_quot;

    assign m_c        = clamp_dim(i_cfg.rows_m);
    assign n_c        = clamp_dim(i_cfg.inner_n);
    assign k_c        = clamp_dim(i_cfg.cols_k);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign start_go   = o_cmd_pop && (i_cmd.kind == smm_pkg::REQ_START)
                     && (m_c != '0) && (k_c != '0);
    assign t_last     = ({1'b0, r_t} + DW'(1)) == r_n;
    assign elem_last  = (({1'b0, r_i} + DW'(1)) == r_m) && (({1'b0, r_j} + DW'(1)) == r_k);
    assign pipe_empty = !r_v1 && !r_v2;
    assign out_free   = !r_out_valid || i_out_ready;
    assign div_start  = (r_state == S_DRAIN) && pipe_empty && r_sc;

    assign a_we    = o_cmd_pop && (i_cmd.kind == smm_pkg::REQ_LOAD_A);
    assign b_we    = o_cmd_pop && (i_cmd.kind == smm_pkg::REQ_LOAD_B);
    assign waddr   = elem_addr(i_cmd.row, i_cmd.col);
    assign a_raddr = elem_addr(r_i, r_t);
    assign b_raddr = r_tr ? elem_addr(r_j, r_t) : elem_addr(r_t, r_j);

    smm_ram #(.WIDTH(EW), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    smm_ram #(.WIDTH(EW), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (i_cmd.value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    smm_div #(.DIVISOR(DIVISOR)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum   (r_acc),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start_go) begin
                    n_state = (n_c == '0) ? S_DRAIN : S_RUN;
                end
            end
            S_RUN: begin
                if (t_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (pipe_empty) begin
                    n_state = r_sc ? S_DIV : S_PUT;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    n_state = elem_last ? S_IDLE : ((r_n == '0) ? S_DRAIN : S_RUN);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_RUN);
            r_v2    <= r_v1;
            if ((r_state == S_PUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(a_rdata) * $signed(b_rdata);
        if (start_go) begin
            r_m   <= m_c;
            r_n   <= n_c;
            r_k   <= k_c;
            r_tr  <= i_cfg.transpose_b;
            r_sc  <= i_cfg.scale_by_root_dmodel;
            r_i   <= '0;
            r_j   <= '0;
            r_t   <= '0;
            r_acc <= '0;
        end else if ((r_state == S_PUT) && out_free) begin
            r_out_row   <= r_i;
            r_out_col   <= r_j;
            r_out_value <= r_sc ? div_quot : r_acc;
            r_out_last  <= elem_last;
            r_acc       <= '0;
            r_t         <= '0;
            if (({1'b0, r_j} + DW'(1)) == r_k) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end else begin
            if (r_state == S_RUN) begin
                r_t <= t_last ? '0 : r_t + 1'b1;
            end
            // floor shift of the 12-fraction-bit product, wrapped to 8 bits
            if (r_v2) begin
                r_acc <= r_acc + r_prod[FB+EW-1:FB];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

`ifndef SYNTH
    a_put_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT) |-> pipe_empty)
        else $error("result taken with products still in flight");

    a_run_t_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ({1'b0, r_t} < r_n))
        else $error("inner index beyond inner size");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside scaling state");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=>
            (r_out_valid && $stable({r_out_row, r_out_col, r_out_value, r_out_last})))
        else $error("result beat changed while waiting");
`endif

endmodule

@@ rtl/scaled_matrix_multiplier.sv @@
// Top level of the scaled matrix multiplier: register file, front queue and execution engine.
// Load beats (A or B element) are taken one per cycle while the command queue has room;
// each is written to its store when the idle engine pops it. Loads with an index at or above
// MAX_DIM and request type 3 are accepted and dropped. A start beat runs C = A*B (or A*B
// transposed) with one shared 8x8 multiply-accumulate unit: each result element steps through
// the inner-sum loop, a drain of the store read and product registers, the reciprocal-multiply
// divider when scaling is on, and the output register; a run stalls while the output waits.
// Results leave in row-major order through an output register, the final one flagged by
// o_last. A two-entry command queue sits between input and engine, so new beats are taken
// while a result waits. Sizes above MAX_DIM are clamped; configuration may only be written
// while no run is in progress. Matrix entries must be loaded before they are used.
module scaled_matrix_multiplier #(
    parameter int MAX_DIM     = smm_pkg::MAX_DIM_DEF,
    parameter int MODEL_WIDTH = smm_pkg::MODEL_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smm_pkg::PADDR_W-1:0]    paddr,
    input  logic [smm_pkg::PDATA_W-1:0]    pwdata,
    output logic [smm_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_req_type,
    input  logic [smm_pkg::IDX_W-1:0]      i_row_index,
    input  logic [smm_pkg::IDX_W-1:0]      i_col_index,
    input  logic signed [smm_pkg::ELEM_W-1:0] i_element_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [smm_pkg::IDX_W-1:0]      o_out_row,
    output logic [smm_pkg::IDX_W-1:0]      o_out_col,
    output logic signed [smm_pkg::ELEM_W-1:0] o_out_value,
    output logic                           o_last
);

    localparam int Divisor = smm_pkg::root_scale(MODEL_WIDTH);
    localparam int DW      = smm_pkg::DIM_W;
    localparam int PW      = smm_pkg::PDATA_W;

    smm_pkg::t_cfg r_cfg;
    smm_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          cmd_pop;
    logic          wr_en;
    logic [2:0]    reg_idx;
    logic [smm_pkg::ELEM_W-1:0] out_value;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_m               <= smm_pkg::RESET_ROWS_M;
            r_cfg.inner_n              <= smm_pkg::RESET_INNER_N;
            r_cfg.cols_k               <= smm_pkg::RESET_COLS_K;
            r_cfg.transpose_b          <= 1'b0;
            r_cfg.scale_by_root_dmodel <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                smm_pkg::REG_ROWS_M:    r_cfg.rows_m               <= pwdata[DW-1:0];
                smm_pkg::REG_INNER_N:   r_cfg.inner_n              <= pwdata[DW-1:0];
                smm_pkg::REG_COLS_K:    r_cfg.cols_k               <= pwdata[DW-1:0];
                smm_pkg::REG_TRANSPOSE: r_cfg.transpose_b          <= pwdata[0];
                smm_pkg::REG_SCALE:     r_cfg.scale_by_root_dmodel <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            smm_pkg::REG_ROWS_M:    prdata = {{(PW-DW){1'b0}}, r_cfg.rows_m};
            smm_pkg::REG_INNER_N:   prdata = {{(PW-DW){1'b0}}, r_cfg.inner_n};
            smm_pkg::REG_COLS_K:    prdata = {{(PW-DW){1'b0}}, r_cfg.cols_k};
            smm_pkg::REG_TRANSPOSE: prdata = {{(PW-1){1'b0}}, r_cfg.transpose_b};
            smm_pkg::REG_SCALE:     prdata = {{(PW-1){1'b0}}, r_cfg.scale_by_root_dmodel};
            default:                prdata = '0;
        endcase
    end

    smm_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_cmd           (cmd),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_pop       (cmd_pop)
    );

    smm_back #(.MAX_DIM(MAX_DIM), .DIVISOR(Divisor)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (out_value),
        .o_last      (o_last)
    );

    assign o_out_value = $signed(out_value);

endmodule

@@ verif/scaled_matrix_multiplier_test.sv @@
// self-checking testbench for the scaled matrix multiplier: loads, products, sizes and scaling
`timescale 1ns / 1ps

module scaled_matrix_multiplier_test;

    localparam int DIM = smm_pkg::MAX_DIM_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_ITEMS = 500;
    localparam int RAND_PHASES = 12;

    typedef struct packed {
        logic [smm_pkg::IDX_W-1:0]         row;
        logic [smm_pkg::IDX_W-1:0]         col;
        logic signed [smm_pkg::ELEM_W-1:0] value;
        logic                              last;
    } t_c_elem;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [smm_pkg::PADDR_W-1:0]       paddr = '0;
    logic [smm_pkg::PDATA_W-1:0]       pwdata = '0;
    logic [smm_pkg::PDATA_W-1:0]       prdata;
    logic                              pready;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [1:0]                        i_req_type = '0;
    logic [smm_pkg::IDX_W-1:0]         i_row_index = '0;
    logic [smm_pkg::IDX_W-1:0]         i_col_index = '0;
    logic signed [smm_pkg::ELEM_W-1:0] i_element_value = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [smm_pkg::IDX_W-1:0]         o_out_row;
    logic [smm_pkg::IDX_W-1:0]         o_out_col;
    logic signed [smm_pkg::ELEM_W-1:0] o_out_value;
    logic                              o_last;

    t_c_elem                           c_elements_due[$];
    logic signed [smm_pkg::ELEM_W-1:0] a_shadow [DIM*DIM];
    logic signed [smm_pkg::ELEM_W-1:0] b_shadow [DIM*DIM];
    bit                                a_loaded [DIM*DIM];
    bit                                b_loaded [DIM*DIM];
    smm_pkg::t_cfg                     mm_cfg;
    int                                scale_div;
    int                                mismatches = 0;
    int                                beats_sent = 0;
    bit                                no_idle = 1'b0;
    int                                out_stall = 0;

    scaled_matrix_multiplier u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_out_value     (o_out_value),
        .o_last          (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int used_dim(input logic [smm_pkg::DIM_W-1:0] v);
        return (v > DIM) ? DIM : int'(v);
    endfunction

    function automatic int div_floor(input int num, input int den);
        int q;
        q = num / den;
        if (num < 0 && q * den != num) q--;
        return q;
    endfunction

    function automatic logic [smm_pkg::ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 8'h80;
            1: return 8'h7f;
            default: return smm_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    function automatic logic [smm_pkg::DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1)
            return smm_pkg::DIM_W'($urandom_range(DIM + 1, (1 << smm_pkg::DIM_W) - 1));
        if (r == 2) return smm_pkg::DIM_W'(DIM);
        return smm_pkg::DIM_W'($urandom_range(1, 4));
    endfunction

    // one beat of C per output element, row-major, accumulator wraps after every add
    task automatic predict_product();
        int m;
        int n;
        int k;
        int full;
        int q;
        logic signed [smm_pkg::ELEM_W-1:0] acc;
        logic signed [smm_pkg::ELEM_W-1:0] a;
        logic signed [smm_pkg::ELEM_W-1:0] b;
        t_c_elem e;
        m = used_dim(mm_cfg.rows_m);
        n = used_dim(mm_cfg.inner_n);
        k = used_dim(mm_cfg.cols_k);
        for (int i = 0; i < m; i++) begin
            for (int j = 0; j < k; j++) begin
                acc = '0;
                for (int t = 0; t < n; t++) begin
                    a = a_shadow[i * DIM + t];
                    b = mm_cfg.transpose_b ? b_shadow[j * DIM + t] : b_shadow[t * DIM + j];
                    full = int'(acc) * (1 << smm_pkg::FRAC_BITS) + int'(a) * int'(b);
                    acc = smm_pkg::ELEM_W'(full >>> smm_pkg::FRAC_BITS);
                end
                if (mm_cfg.scale_by_root_dmodel) begin
                    q = div_floor(int'(acc) * (1 << smm_pkg::FRAC_BITS), scale_div);
                    acc = smm_pkg::ELEM_W'(q);
                end
                e.row = smm_pkg::IDX_W'(i);
                e.col = smm_pkg::IDX_W'(j);
                e.value = acc;
                e.last = (i == m - 1) && (j == k - 1);
                c_elements_due.push_back(e);
            end
        end
    endtask

    task automatic send_beat(input logic [1:0] kind, input logic [smm_pkg::IDX_W-1:0] row,
                             input logic [smm_pkg::IDX_W-1:0] col,
                             input logic [smm_pkg::ELEM_W-1:0] value);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_row_index <= row;
        i_col_index <= col;
        i_element_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        case (kind)
            smm_pkg::REQ_LOAD_A: begin
                a_shadow[int'(row) * DIM + int'(col)] = value;
                a_loaded[int'(row) * DIM + int'(col)] = 1'b1;
            end
            smm_pkg::REQ_LOAD_B: begin
                b_shadow[int'(row) * DIM + int'(col)] = value;
                b_loaded[int'(row) * DIM + int'(col)] = 1'b1;
            end
            smm_pkg::REQ_START: predict_product();
            default: ;
        endcase
        if (kind != REQ_UNUSED) beats_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (c_elements_due.size() != 0);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [smm_pkg::DIM_W-1:0] value);
        logic [smm_pkg::PDATA_W-1:0] data;
        data = $urandom;
        if (idx == smm_pkg::REG_TRANSPOSE || idx == smm_pkg::REG_SCALE) data[0] = value[0];
        else data[smm_pkg::DIM_W-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= smm_pkg::PADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            smm_pkg::REG_ROWS_M:    mm_cfg.rows_m = data[smm_pkg::DIM_W-1:0];
            smm_pkg::REG_INNER_N:   mm_cfg.inner_n = data[smm_pkg::DIM_W-1:0];
            smm_pkg::REG_COLS_K:    mm_cfg.cols_k = data[smm_pkg::DIM_W-1:0];
            smm_pkg::REG_TRANSPOSE: mm_cfg.transpose_b = data[0];
            smm_pkg::REG_SCALE:     mm_cfg.scale_by_root_dmodel = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [smm_pkg::DIM_W-1:0] m,
                              input logic [smm_pkg::DIM_W-1:0] n,
                              input logic [smm_pkg::DIM_W-1:0] k,
                              input logic tr, input logic sc);
        write_reg(smm_pkg::REG_ROWS_M, m);
        write_reg(smm_pkg::REG_INNER_N, n);
        write_reg(smm_pkg::REG_COLS_K, k);
        write_reg(smm_pkg::REG_TRANSPOSE, smm_pkg::DIM_W'(tr));
        write_reg(smm_pkg::REG_SCALE, smm_pkg::DIM_W'(sc));
    endtask

    // never let a run read a store entry that has not been written
    task automatic load_missing_operands();
        int m;
        int n;
        int k;
        int slot;
        m = used_dim(mm_cfg.rows_m);
        n = used_dim(mm_cfg.inner_n);
        k = used_dim(mm_cfg.cols_k);
        for (int i = 0; i < m; i++) begin
            for (int t = 0; t < n; t++) begin
                if (!a_loaded[i * DIM + t])
                    send_beat(smm_pkg::REQ_LOAD_A, smm_pkg::IDX_W'(i), smm_pkg::IDX_W'(t),
                              rand_elem());
            end
        end
        for (int t = 0; t < n; t++) begin
            for (int j = 0; j < k; j++) begin
                slot = mm_cfg.transpose_b ? j * DIM + t : t * DIM + j;
                if (!b_loaded[slot])
                    send_beat(smm_pkg::REQ_LOAD_B, smm_pkg::IDX_W'(slot / DIM),
                              smm_pkg::IDX_W'(slot % DIM), rand_elem());
            end
        end
    endtask

    task automatic run_product();
        load_missing_operands();
        send_beat(smm_pkg::REQ_START, smm_pkg::IDX_W'($urandom), smm_pkg::IDX_W'($urandom),
                  smm_pkg::ELEM_W'($urandom));
    endtask

    task automatic test_extremes();
        set_config(4'd2, 4'd2, 4'd2, 1'b0, 1'b0);
        send_beat(smm_pkg::REQ_LOAD_A, 3'd0, 3'd0, 8'h80);
        send_beat(smm_pkg::REQ_LOAD_A, 3'd0, 3'd1, 8'h7f);
        send_beat(smm_pkg::REQ_LOAD_A, 3'd1, 3'd0, 8'h40);
        send_beat(smm_pkg::REQ_LOAD_A, 3'd1, 3'd1, 8'hff);
        send_beat(smm_pkg::REQ_LOAD_B, 3'd0, 3'd0, 8'h80);
        send_beat(smm_pkg::REQ_LOAD_B, 3'd0, 3'd1, 8'h7f);
        send_beat(smm_pkg::REQ_LOAD_B, 3'd1, 3'd0, 8'hc0);
        send_beat(smm_pkg::REQ_LOAD_B, 3'd1, 3'd1, 8'h01);
        send_beat(smm_pkg::REQ_LOAD_A, 3'd7, 3'd7, 8'h7f);
        send_beat(smm_pkg::REQ_LOAD_B, 3'd7, 3'd7, 8'h80);
        // ignored request type, must not touch the stores
        send_beat(REQ_UNUSED, 3'd0, 3'd0, 8'h55);
        send_beat(smm_pkg::REQ_START, 3'd0, 3'd0, 8'h00);
    endtask

    task automatic test_transpose_and_scale();
        wait_idle();
        write_reg(smm_pkg::REG_TRANSPOSE, 4'd1);
        run_product();
        wait_idle();
        write_reg(smm_pkg::REG_SCALE, 4'd1);
        run_product();
        wait_idle();
        write_reg(smm_pkg::REG_TRANSPOSE, 4'd0);
        run_product();
    endtask

    task automatic test_degenerate_sizes();
        wait_idle();
        write_reg(smm_pkg::REG_INNER_N, 4'd0);
        run_product();
        wait_idle();
        write_reg(smm_pkg::REG_INNER_N, 4'd2);
        write_reg(smm_pkg::REG_ROWS_M, 4'd0);
        run_product();
        wait_idle();
        write_reg(smm_pkg::REG_ROWS_M, 4'd2);
        write_reg(smm_pkg::REG_COLS_K, 4'd0);
        run_product();
    endtask

    task automatic test_random_phases();
        int goal;
        int pick;
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            if (p == 1)
                set_config('1, '1, '1, 1'b1, 1'b1);
            else if (p == 2)
                set_config(smm_pkg::DIM_W'(DIM), smm_pkg::DIM_W'(DIM), smm_pkg::DIM_W'(DIM),
                           1'b0, 1'b0);
            else
                set_config(pick_dim(), pick_dim(), pick_dim(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            no_idle = (p >= RAND_PHASES - 2) || ($urandom_range(0, 3) == 0);
            goal = beats_sent + RAND_ITEMS / RAND_PHASES;
            while (beats_sent < goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 5) begin
                    send_beat(REQ_UNUSED, smm_pkg::IDX_W'($urandom), smm_pkg::IDX_W'($urandom),
                              rand_elem());
                end else if (pick < 20) begin
                    run_product();
                    if ($urandom_range(0, 5) == 0) drain_results();
                end else begin
                    send_beat(pick[0] ? smm_pkg::REQ_LOAD_B : smm_pkg::REQ_LOAD_A,
                              smm_pkg::IDX_W'($urandom), smm_pkg::IDX_W'($urandom),
                              rand_elem());
                end
            end
            run_product();
        end
    endtask

    always @(posedge i_clk) begin
        if (no_idle) begin
            i_out_ready <= 1'b1;
            out_stall <= 0;
        end else if (out_stall != 0) begin
            i_out_ready <= 1'b0;
            out_stall <= out_stall - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            out_stall <= $urandom_range(0, 4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_c_elem want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (c_elements_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: row %0d col %0d value %0d last %0b",
                             o_out_row, o_out_col, o_out_value, o_last);
            end else begin
                want = c_elements_due.pop_front();
                if (o_out_row !== want.row || o_out_col !== want.col ||
                    o_out_value !== want.value || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("C beat: expected row %0d col %0d value %0d last %0b, got %s",
                                 want.row, want.col, want.value, want.last,
                                 $sformatf("row %0d col %0d value %0d last %0b",
                                           o_out_row, o_out_col, o_out_value, o_last));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet = 0;
            else quiet++;
        end
        $display("scaled_matrix_multiplier_test: errors");
        $finish;
    end

    initial begin
        // 64 * sqrt(model width), rounded to nearest
        scale_div = $rtoi($sqrt(real'(smm_pkg::MODEL_WIDTH_DEF) * 4096.0) + 0.5);
        mm_cfg = '{rows_m: smm_pkg::RESET_ROWS_M, inner_n: smm_pkg::RESET_INNER_N,
                   cols_k: smm_pkg::RESET_COLS_K,
                   transpose_b: 1'b0, scale_by_root_dmodel: 1'b0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_transpose_and_scale();
        test_degenerate_sizes();
        test_random_phases();
        wait_idle();
        if (mismatches == 0 && c_elements_due.size() == 0) begin
            $display("scaled_matrix_multiplier_test: clean");
        end else begin
            $display("scaled_matrix_multiplier_test: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_div.sv
rtl/smm_front.sv
rtl/smm_back.sv
rtl/scaled_matrix_multiplier.sv
verif/scaled_matrix_multiplier_test.sv
